// File: rtl/drfd_pkg.sv
// Shared types, constants and the CRC-8 byte step for the range frame deframer.
package drfd_pkg;

   localparam logic [7:0] FRAME_MARK  = 8'h54;
   localparam int         FRAME_DEPTH = 7;
   localparam int         CNT_W       = 3;
   localparam logic [CNT_W-1:0] SINGLE_LEN = 3'd4;
   localparam logic [CNT_W-1:0] DUAL_LEN   = 3'd7;

   // Configuration register indexes.
   localparam logic [2:0] REG_CRC_POLY  = 3'd0;
   localparam logic [2:0] REG_TOO_CLOSE = 3'd1;
   localparam logic [2:0] REG_IR_OUT    = 3'd2;
   localparam logic [2:0] REG_US_OUT    = 3'd3;
   localparam logic [2:0] REG_IR_MIN    = 3'd4;
   localparam logic [2:0] REG_IR_MAX    = 3'd5;
   localparam logic [2:0] REG_US_MIN    = 3'd6;
   localparam logic [2:0] REG_US_MAX    = 3'd7;

   // Result status codes.
   localparam logic [1:0] ST_VALID     = 2'd0;
   localparam logic [1:0] ST_TOO_CLOSE = 2'd1;
   localparam logic [1:0] ST_TOO_FAR   = 2'd2;

   localparam logic SENSOR_IR = 1'b0;
   localparam logic SENSOR_US = 1'b1;

   typedef struct packed {
      logic [7:0]  crc_poly;
      logic [15:0] too_close_code;
      logic [15:0] ir_out_code;
      logic [15:0] us_out_code;
      logic [14:0] ir_min_mm;
      logic [14:0] ir_max_mm;
      logic [14:0] us_min_mm;
      logic [14:0] us_max_mm;
   } cfg_type;

   typedef struct packed {
      logic        sensor;
      logic [1:0]  status;
      logic [15:0] range_mm;
      logic [31:0] frame_seq;
      logic        last;
   } result_type;

   typedef struct packed {
      logic       sweep;
      logic [1:0] res_num;
   } asm_status_type;

   // One byte of an MSB-first CRC-8 with zero init.
   function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] data,
                                            input logic [7:0] poly);
      logic [7:0] c;
      c = crc ^ data;
      for (int b = 0; b < 8; b++) begin
         if (c[7]) begin
            c = {c[6:0], 1'b0} ^ poly;
         end else begin
            c = {c[6:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage

// File: rtl/drfd_classify.sv
// Range classification of one raw 16-bit reading against its codes and limits.
module drfd_classify
   import drfd_pkg::*;
(
   input  logic [15:0] raw,
   input  logic [15:0] too_close_code,
   input  logic [15:0] out_code,
   input  logic [14:0] min_mm,
   input  logic [14:0] max_mm,
   output logic [1:0]  status
);

   logic signed [16:0] value;
   logic signed [16:0] min_value;
   logic signed [16:0] max_value;

   assign value     = $signed({raw[15], raw});
   assign min_value = $signed({2'b00, min_mm});
   assign max_value = $signed({2'b00, max_mm});

   // The special codes win over the numeric compare.
   always_comb begin
      if (raw == too_close_code) begin
         status = ST_TOO_CLOSE;
      end else if (raw == out_code) begin
         status = ST_TOO_FAR;
      end else if (value > max_value) begin
         status = ST_TOO_FAR;
      end else if (value < min_value) begin
         status = ST_TOO_CLOSE;
      end else begin
         status = ST_VALID;
      end
   end

endmodule

// File: rtl/drfd_assembler.sv
// Frame buffer, running CRC, sequence counter and result building.
module drfd_assembler
   import drfd_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  cfg_type        cfg,
   input  logic           poly_write,
   input  logic           byte_fire,
   input  logic [7:0]     rx_byte,
   output asm_status_type stat,
   output result_type     res0,
   output result_type     res1
);

   logic [7:0]       bytes_ff [FRAME_DEPTH];
   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;
   logic [7:0]       crc_ff;
   logic [7:0]       crc_in;
   logic [31:0]      seq_ff;
   logic [31:0]      seq_in;
   logic             sweep_ff;
   logic             sweep_in;
   logic [CNT_W-1:0] sw_idx_ff;
   logic [CNT_W-1:0] sw_idx_in;

   logic [CNT_W-1:0] sel_idx;
   logic [7:0]       sel_byte;
   logic [7:0]       crc_next;
   logic             is_mark;
   logic             store;
   logic             single_ok;
   logic             dual_ok;
   logic [1:0]       res_num;
   logic [31:0]      seq_plus;
   logic [1:0]       ir_status;
   logic [1:0]       us_status;
   logic             sweep_step;

   // The CRC register trails the buffer by one byte: it covers all held bytes but the
   // newest, so at a frame mark it already holds the CRC over everything before the
   // check byte.
   assign is_mark    = (rx_byte == FRAME_MARK);
   assign store      = byte_fire && !is_mark && (count_ff != DUAL_LEN);
   assign sweep_step = sweep_ff && (({1'b0, sw_idx_ff} + 4'd1) < {1'b0, count_ff});
   assign sel_idx    = sweep_ff ? sw_idx_ff : (count_ff - 3'd1);

   always_comb begin
      sel_byte = 8'h00;
      for (int k = 0; k < FRAME_DEPTH; k++) begin
         if (sel_idx == CNT_W'(k)) begin
            sel_byte = bytes_ff[k];
         end
      end
   end

   assign crc_next  = crc8_byte(crc_ff, sel_byte, cfg.crc_poly);
   assign single_ok = (count_ff == SINGLE_LEN) && (crc_ff == bytes_ff[3]);
   assign dual_ok   = (count_ff == DUAL_LEN) && (crc_ff == bytes_ff[6]);

   always_comb begin
      res_num = 2'd0;
      if (byte_fire && is_mark) begin
         if (single_ok) begin
            res_num = 2'd1;
         end else if (dual_ok) begin
            res_num = 2'd2;
         end
      end
   end

   assign seq_plus = seq_ff + 32'd1;

   drfd_classify u_ir_class (
      .raw            ({bytes_ff[1], bytes_ff[2]}),
      .too_close_code (cfg.too_close_code),
      .out_code       (cfg.ir_out_code),
      .min_mm         (cfg.ir_min_mm),
      .max_mm         (cfg.ir_max_mm),
      .status         (ir_status)
   );

   drfd_classify u_us_class (
      .raw            ({bytes_ff[4], bytes_ff[5]}),
      .too_close_code (cfg.too_close_code),
      .out_code       (cfg.us_out_code),
      .min_mm         (cfg.us_min_mm),
      .max_mm         (cfg.us_max_mm),
      .status         (us_status)
   );

   always_comb begin
      res0.sensor    = SENSOR_IR;
      res0.status    = ir_status;
      res0.range_mm  = {bytes_ff[1], bytes_ff[2]};
      res0.frame_seq = seq_ff;
      res0.last      = (count_ff == SINGLE_LEN);
      res1.sensor    = SENSOR_US;
      res1.status    = us_status;
      res1.range_mm  = {bytes_ff[4], bytes_ff[5]};
      res1.frame_seq = seq_plus;
      res1.last      = 1'b1;
   end

   assign stat.sweep   = sweep_ff;
   assign stat.res_num = res_num;

   always_comb begin
      count_in  = count_ff;
      crc_in    = crc_ff;
      seq_in    = seq_ff;
      sweep_in  = sweep_ff;
      sw_idx_in = sw_idx_ff;
      if (poly_write) begin
         // A new polynomial invalidates the running CRC: rebuild it from the held bytes.
         sweep_in  = 1'b1;
         sw_idx_in = '0;
         crc_in    = 8'h00;
      end else if (sweep_ff) begin
         if (sweep_step) begin
            crc_in    = crc_next;
            sw_idx_in = sw_idx_ff + 3'd1;
         end else begin
            sweep_in = 1'b0;
         end
      end else if (byte_fire) begin
         if (store) begin
            count_in = count_ff + 3'd1;
            if (count_ff != '0) begin
               crc_in = crc_next;
            end
         end else begin
            count_in = 3'd1;
            crc_in   = 8'h00;
         end
         if (res_num != 2'd0) begin
            seq_in = seq_plus;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         crc_ff    <= 8'h00;
         seq_ff    <= 32'd0;
         sweep_ff  <= 1'b0;
         sw_idx_ff <= '0;
      end else begin
         count_ff  <= count_in;
         crc_ff    <= crc_in;
         seq_ff    <= seq_in;
         sweep_ff  <= sweep_in;
         sw_idx_ff <= sw_idx_in;
      end
   end

   // Bytes past the fill count are never read, so the buffer needs no reset.
   always_ff @(posedge clock) begin
      if (byte_fire && !sweep_ff && !poly_write) begin
         if (store) begin
            bytes_ff[count_ff] <= rx_byte;
         end else begin
            bytes_ff[0] <= FRAME_MARK;
         end
      end
   end

endmodule

// File: rtl/dual_range_frame_deframer.sv
// Top level of the dual range frame deframer: ports, registers, input and result staging.
//
// The block takes one received byte per cycle while it does not stall and returns one or
// two range results for each frame that passes its CRC check. A byte is captured in an
// input register and is then worked into the frame buffer. The first result of a frame
// is registered in the result buffer once the closing 'T' is worked in, and is presented
// at the result port from there. A dual-sensor frame gives its infrared result first and
// its ultrasound result after it. A byte that closes a frame waits in the input
// register while results of the previous frame are still held, since the two-entry
// result buffer sets that limit; ordinary bytes never wait outside a CRC rebuild.
// Writing crc_poly starts a rebuild of the running CRC over the bytes already held, one
// byte per cycle for up to six bytes. The byte in the input register is held back in the
// write cycle and until the rebuild has finished.
module dual_range_frame_deframer
   import drfd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_rx_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_sensor,
   output logic [1:0]  rsp_status,
   output logic signed [15:0] rsp_range_mm,
   output logic [31:0] rsp_frame_seq,
   output logic        rsp_last,
   input  logic        csr_wr_en,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_wr_data
);

   cfg_type        cfg_ff;
   cfg_type        cfg_in;
   logic           in_vld_ff;
   logic           in_vld_in;
   logic [7:0]     in_byte_ff;
   result_type     out_ff [2];
   result_type     out_in [2];
   logic [1:0]     out_cnt_ff;
   logic [1:0]     out_cnt_in;

   asm_status_type stat;
   result_type     res0;
   result_type     res1;
   logic           req_take;
   logic           rsp_take;
   logic           out_free;
   logic           proc_fire;
   logic           poly_write;

   // Configuration registers.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (csr_index)
            REG_CRC_POLY:  cfg_in.crc_poly       = csr_wr_data[7:0];
            REG_TOO_CLOSE: cfg_in.too_close_code = csr_wr_data;
            REG_IR_OUT:    cfg_in.ir_out_code    = csr_wr_data;
            REG_US_OUT:    cfg_in.us_out_code    = csr_wr_data;
            REG_IR_MIN:    cfg_in.ir_min_mm      = csr_wr_data[14:0];
            REG_IR_MAX:    cfg_in.ir_max_mm      = csr_wr_data[14:0];
            REG_US_MIN:    cfg_in.us_min_mm      = csr_wr_data[14:0];
            REG_US_MAX:    cfg_in.us_max_mm      = csr_wr_data[14:0];
            default:       cfg_in = cfg_ff;
         endcase
      end
   end

   assign poly_write = csr_wr_en && (csr_index == REG_CRC_POLY);

   // Handshakes. A closing mark may produce results, so it only moves on when the result
   // buffer will be empty at this edge; other bytes move on unless a CRC rebuild holds them.
   assign rsp_valid = (out_cnt_ff != 2'd0);
   assign rsp_take  = rsp_valid && !rsp_stall;
   assign out_free  = (out_cnt_ff == 2'd0) || ((out_cnt_ff == 2'd1) && rsp_take);
   assign proc_fire = in_vld_ff && !stat.sweep && !poly_write &&
                      ((in_byte_ff != FRAME_MARK) || out_free);
   assign req_stall = in_vld_ff && !proc_fire;
   assign req_take  = req_valid && !req_stall;

   always_comb begin
      in_vld_in = in_vld_ff;
      if (req_take) begin
         in_vld_in = 1'b1;
      end else if (proc_fire) begin
         in_vld_in = 1'b0;
      end
   end

   drfd_assembler u_assembler (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .poly_write (poly_write),
      .byte_fire  (proc_fire),
      .rx_byte    (in_byte_ff),
      .stat       (stat),
      .res0       (res0),
      .res1       (res1)
   );

   // Two-entry result buffer; the head is always entry zero.
   always_comb begin
      out_in[0]  = out_ff[0];
      out_in[1]  = out_ff[1];
      out_cnt_in = out_cnt_ff;
      if (rsp_take) begin
         out_in[0]  = out_ff[1];
         out_cnt_in = out_cnt_ff - 2'd1;
      end
      if (stat.res_num != 2'd0) begin
         out_in[0]  = res0;
         out_in[1]  = res1;
         out_cnt_in = stat.res_num;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.crc_poly       <= 8'd7;
         cfg_ff.too_close_code <= 16'd0;
         cfg_ff.ir_out_code    <= 16'hFFFF;
         cfg_ff.us_out_code    <= 16'hFFFF;
         cfg_ff.ir_min_mm      <= 15'd200;
         cfg_ff.ir_max_mm      <= 15'd14000;
         cfg_ff.us_min_mm      <= 15'd50;
         cfg_ff.us_max_mm      <= 15'd7650;
         in_vld_ff             <= 1'b0;
         out_cnt_ff            <= 2'd0;
      end else begin
         cfg_ff     <= cfg_in;
         in_vld_ff  <= in_vld_in;
         out_cnt_ff <= out_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_byte_ff <= req_rx_byte;
      end
      out_ff[0] <= out_in[0];
      out_ff[1] <= out_in[1];
   end

   assign rsp_sensor    = out_ff[0].sensor;
   assign rsp_status    = out_ff[0].status;
   assign rsp_range_mm  = $signed(out_ff[0].range_mm);
   assign rsp_frame_seq = out_ff[0].frame_seq;
   assign rsp_last      = out_ff[0].last;

   // A full buffer always holds an infrared result followed by its ultrasound partner.
   a_pair_order: assert property (@(posedge clock) disable iff (reset)
      (out_cnt_ff == 2'd2) |-> (!out_ff[0].last && out_ff[1].last &&
                                out_ff[0].sensor == SENSOR_IR &&
                                out_ff[1].sensor == SENSOR_US))
      else $error("result pair out of order");

   // The ultrasound result carries the next sequence number.
   a_pair_seq: assert property (@(posedge clock) disable iff (reset)
      (out_cnt_ff == 2'd2) |-> (out_ff[1].frame_seq == out_ff[0].frame_seq + 32'd1))
      else $error("ultrasound sequence number mismatch");

   // A polynomial write always starts a CRC rebuild.
   a_poly_sweep: assert property (@(posedge clock) disable iff (reset)
      poly_write |=> stat.sweep)
      else $error("CRC rebuild did not start");

   // New results only land in an empty buffer.
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      (stat.res_num != 2'd0) |-> out_free)
      else $error("result buffer overrun");

endmodule

// File: sim/tb_top.sv
// Self-checking testbench for the dual range frame deframer: frame stimulus, prediction, checks.
`timescale 1ns / 100ps

module tb_top;
   import drfd_pkg::*;

   // Receiver hold-off length for the backpressure test, in clock cycles.
   localparam int HOLD_CYCLES = 400;
   // Cycles allowed for the block to settle once nothing more is expected.
   localparam int SETTLE_CYCLES = 10;

   // Kinds of damage a generated frame can carry.
   typedef enum int {FLAW_NONE, FLAW_CRC, FLAW_SHORT, FLAW_LONG} flaw_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_rx_byte = 8'h00;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic        rsp_sensor;
   logic [1:0]  rsp_status;
   logic signed [15:0] rsp_range_mm;
   logic [31:0] rsp_frame_seq;
   logic        rsp_last;
   logic        csr_wr_en = 1'b0;
   logic [2:0]  csr_index = 3'd0;
   logic [15:0] csr_wr_data = 16'h0000;

   dual_range_frame_deframer uut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_rx_byte  (req_rx_byte),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_sensor   (rsp_sensor),
      .rsp_status   (rsp_status),
      .rsp_range_mm (rsp_range_mm),
      .rsp_frame_seq(rsp_frame_seq),
      .rsp_last     (rsp_last),
      .csr_wr_en    (csr_wr_en),
      .csr_index    (csr_index),
      .csr_wr_data  (csr_wr_data)
   );

   // The 12 ns clock: six nanoseconds high, six low.
   always begin
      clock = 1'b1;
      #6;
      clock = 1'b0;
      #6;
   end

   // Shared state of the testbench. The idle percentages decide how often the
   // sender leaves a gap before an item and how often the receiver stalls.
   int req_idle_pct = 0;
   int rsp_idle_pct = 0;
   int items_sent = 0;
   int error_count = 0;

   // Our own copy of the block's state: the configuration as last written,
   // the bytes of the frame in hand, how many are held, and the frame counter.
   cfg_type         regs;
   logic [6:0][7:0] held_bytes;
   int              held_count;
   logic [31:0]     frame_count;

   // Range results still owed by the block, oldest first.
   result_type expected_ranges[$];

   // Long receiver hold-off. The test raises hold_go; this process then keeps
   // the result channel stalled until its own countdown from HOLD_CYCLES ends.
   logic hold_go = 1'b0;
   logic hold_seen = 1'b0;
   int   hold_left = 0;

   always @(posedge clock) begin
      if (hold_go && !hold_seen) begin
         hold_seen <= 1'b1;
         hold_left <= HOLD_CYCLES;
         rsp_stall <= 1'b1;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < rsp_idle_pct);
      end
      if (!hold_go) begin
         hold_seen <= 1'b0;
      end
   end

   // Prints one line for a mismatch and counts it.
   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      error_count++;
      $display("mismatch at %0t ns: %s got %0h expected %0h", $time, what, got, want);
   endtask

   // Every accepted result is compared field by field with the oldest expected one.
   // Outputs are read right at the edge, before any of this edge's updates land.
   always @(posedge clock) begin : check_results
      result_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         if (expected_ranges.size() == 0) begin
            report_mismatch("result with nothing expected, range", 32'(rsp_range_mm), 32'h0);
         end else begin
            want = expected_ranges.pop_front();
            if (rsp_sensor !== want.sensor) begin
               report_mismatch("sensor", 32'(rsp_sensor), 32'(want.sensor));
            end
            if (rsp_status !== want.status) begin
               report_mismatch("status", 32'(rsp_status), 32'(want.status));
            end
            if (rsp_range_mm !== want.range_mm) begin
               report_mismatch("range_mm", 32'(rsp_range_mm), 32'(want.range_mm));
            end
            if (rsp_frame_seq !== want.frame_seq) begin
               report_mismatch("frame_seq", rsp_frame_seq, want.frame_seq);
            end
            if (rsp_last !== want.last) begin
               report_mismatch("last", 32'(rsp_last), 32'(want.last));
            end
         end
      end
   end

   // MSB-first CRC-8 with zero start value over the first len bytes of a frame.
   // The predictor uses it to check frames and the generator to build them.
   function automatic logic [7:0] crc8_over(input logic [6:0][7:0] bytes, input int len,
                                            input logic [7:0] poly);
      logic [7:0] acc;
      acc = 8'h00;
      for (int i = 0; i < len; i++) begin
         acc = acc ^ bytes[i];
         for (int k = 0; k < 8; k++) begin
            acc = acc[7] ? ({acc[6:0], 1'b0} ^ poly) : {acc[6:0], 1'b0};
         end
      end
      return acc;
   endfunction

   // Classifies a raw reading. The too-close code wins over the out-of-range
   // code; only then is the signed value held against the limits.
   function automatic logic [1:0] range_status(input logic [15:0] raw,
                                               input logic [15:0] out_code,
                                               input logic [14:0] min_mm,
                                               input logic [14:0] max_mm);
      int value;
      value = int'($signed(raw));
      if (raw == regs.too_close_code) begin
         return ST_TOO_CLOSE;
      end
      if (raw == out_code) begin
         return ST_TOO_FAR;
      end
      if (value > int'(max_mm)) begin
         return ST_TOO_FAR;
      end
      if (value < int'(min_mm)) begin
         return ST_TOO_CLOSE;
      end
      return ST_VALID;
   endfunction

   function automatic result_type range_result(input logic sensor, input logic [15:0] raw,
                                               input logic is_last);
      result_type r;
      r.sensor    = sensor;
      r.range_mm  = raw;
      r.frame_seq = frame_count;
      r.last      = is_last;
      if (sensor == SENSOR_IR) begin
         r.status = range_status(raw, regs.ir_out_code, regs.ir_min_mm, regs.ir_max_mm);
      end else begin
         r.status = range_status(raw, regs.us_out_code, regs.us_min_mm, regs.us_max_mm);
      end
      return r;
   endfunction

   // Works one accepted byte into our copy of the frame buffer and queues the
   // results that it causes. Only a 'T' can close a frame: with four bytes held
   // it is a single-sensor frame, with seven a dual one. Any 'T', and a data
   // byte that arrives with the buffer already full, restarts the buffer as 'T'.
   task automatic predict_byte(input logic [7:0] b);
      if (b != FRAME_MARK && held_count < FRAME_DEPTH) begin
         held_bytes[held_count] = b;
         held_count++;
      end else begin
         if (b == FRAME_MARK) begin
            if (held_count == int'(SINGLE_LEN)) begin
               if (crc8_over(held_bytes, int'(SINGLE_LEN) - 1, regs.crc_poly)
                   == held_bytes[SINGLE_LEN - 1]) begin
                  expected_ranges.push_back(
                     range_result(SENSOR_IR, {held_bytes[1], held_bytes[2]}, 1'b1));
                  frame_count++;
               end
            end else if (held_count == FRAME_DEPTH) begin
               if (crc8_over(held_bytes, FRAME_DEPTH - 1, regs.crc_poly)
                   == held_bytes[FRAME_DEPTH - 1]) begin
                  // The ultrasound result carries the counter already advanced
                  // by the infrared one; the frame advances it only once.
                  expected_ranges.push_back(
                     range_result(SENSOR_IR, {held_bytes[1], held_bytes[2]}, 1'b0));
                  frame_count++;
                  expected_ranges.push_back(
                     range_result(SENSOR_US, {held_bytes[4], held_bytes[5]}, 1'b1));
               end
            end
         end
         held_bytes    = '0;
         held_bytes[0] = FRAME_MARK;
         held_count    = 1;
      end
   endtask

   // Offers one item, holding it steady until it is accepted, then predicts it.
   // The sender may first leave a random gap; valid stays high between items
   // that follow each other without a gap.
   task automatic send_byte(input logic [7:0] b);
      while ($urandom_range(0, 99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_rx_byte <= b;
      do begin
         @(posedge clock);
      end while (req_stall !== 1'b0);
      items_sent++;
      predict_byte(b);
   endtask

   // Lowers valid and waits until every expected result has arrived and the
   // block has had time to finish any byte that causes no result.
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (expected_ranges.size() != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Writes one register and updates our copy of it. Write enable is left high
   // so that writes can follow each other; load_settings lowers it at the end.
   task automatic write_reg(input logic [2:0] index, input logic [15:0] value);
      csr_wr_en   <= 1'b1;
      csr_index   <= index;
      csr_wr_data <= value;
      @(posedge clock);
      case (index)
         REG_CRC_POLY:  regs.crc_poly       = value[7:0];
         REG_TOO_CLOSE: regs.too_close_code = value;
         REG_IR_OUT:    regs.ir_out_code    = value;
         REG_US_OUT:    regs.us_out_code    = value;
         REG_IR_MIN:    regs.ir_min_mm      = value[14:0];
         REG_IR_MAX:    regs.ir_max_mm      = value[14:0];
         REG_US_MIN:    regs.us_min_mm      = value[14:0];
         REG_US_MAX:    regs.us_max_mm      = value[14:0];
         default: ;
      endcase
   endtask

   // Loads a full register set once the block has gone idle.
   task automatic load_settings(input cfg_type c);
      wait_idle();
      write_reg(REG_CRC_POLY, {8'h00, c.crc_poly});
      write_reg(REG_TOO_CLOSE, c.too_close_code);
      write_reg(REG_IR_OUT, c.ir_out_code);
      write_reg(REG_US_OUT, c.us_out_code);
      write_reg(REG_IR_MIN, {1'b0, c.ir_min_mm});
      write_reg(REG_IR_MAX, {1'b0, c.ir_max_mm});
      write_reg(REG_US_MIN, {1'b0, c.us_min_mm});
      write_reg(REG_US_MAX, {1'b0, c.us_max_mm});
      csr_wr_en <= 1'b0;
   endtask

   // A register set with random polynomial and codes. Limits are mostly
   // ordered, but now and then the minimum lies above the maximum.
   function automatic cfg_type random_settings();
      cfg_type c;
      c.crc_poly       = 8'($urandom_range(1, 255));
      c.too_close_code = $urandom_range(0, 1) ? 16'h0000 : 16'($urandom);
      c.ir_out_code    = $urandom_range(0, 1) ? 16'hFFFF : 16'($urandom);
      c.us_out_code    = $urandom_range(0, 1) ? 16'hFFFF : 16'($urandom);
      c.ir_min_mm      = 15'($urandom_range(0, 2000));
      c.ir_max_mm      = 15'($urandom_range(int'(c.ir_min_mm), 32767));
      c.us_min_mm      = 15'($urandom_range(0, 2000));
      c.us_max_mm      = 15'($urandom_range(int'(c.us_min_mm), 32767));
      if ($urandom_range(0, 9) == 0) begin
         c.us_min_mm = 15'($urandom_range(20000, 32767));
         c.ir_max_mm = 15'($urandom_range(0, 100));
      end
      return c;
   endfunction

   // A random byte that never closes a frame.
   function automatic logic [7:0] plain_byte();
      logic [7:0] b;
      b = 8'($urandom_range(0, 255));
      if (b == FRAME_MARK) begin
         b = 8'h55;
      end
      return b;
   endfunction

   // A raw reading aimed at the classification edges of one sensor: the codes,
   // the limits and their neighbors, negative values and plain random ones.
   function automatic logic [15:0] pick_range(input logic sensor);
      logic [15:0] out_code;
      logic [14:0] min_mm;
      logic [14:0] max_mm;
      out_code = (sensor == SENSOR_IR) ? regs.ir_out_code : regs.us_out_code;
      min_mm   = (sensor == SENSOR_IR) ? regs.ir_min_mm : regs.us_min_mm;
      max_mm   = (sensor == SENSOR_IR) ? regs.ir_max_mm : regs.us_max_mm;
      case ($urandom_range(0, 9))
         0: return regs.too_close_code;
         1: return out_code;
         2: return {1'b0, min_mm};
         3: return {1'b0, min_mm} - 16'd1;
         4: return {1'b0, max_mm};
         5: return {1'b0, max_mm} + 16'd1;
         6: return {1'b1, 15'($urandom)};
         7: return 16'($urandom);
         default: return 16'($urandom_range(int'(min_mm), int'(max_mm)));
      endcase
   endfunction

   // Sends a frame from its opening 'T' up to its CRC byte; the next 'T' sent
   // closes it. A flaw corrupts the CRC, cuts the frame short or overruns it.
   task automatic send_frame(input logic dual, input logic [15:0] ir_raw,
                             input logic [15:0] us_raw, input flaw_type flaw);
      logic [6:0][7:0] f;
      int len;
      f    = '0;
      f[0] = FRAME_MARK;
      f[1] = ir_raw[15:8];
      f[2] = ir_raw[7:0];
      if (dual) begin
         f[3] = plain_byte();
         f[4] = us_raw[15:8];
         f[5] = us_raw[7:0];
         f[6] = crc8_over(f, FRAME_DEPTH - 1, regs.crc_poly);
         len  = FRAME_DEPTH;
      end else begin
         f[3] = crc8_over(f, int'(SINGLE_LEN) - 1, regs.crc_poly);
         len  = int'(SINGLE_LEN);
      end
      case (flaw)
         FLAW_CRC:   f[len - 1] = f[len - 1] ^ 8'($urandom_range(1, 255));
         FLAW_SHORT: len = $urandom_range(1, len - 1);
         default: ;
      endcase
      for (int i = 0; i < len; i++) begin
         send_byte(f[i]);
      end
      if (flaw == FLAW_LONG) begin
         repeat ($urandom_range(1, 4)) send_byte(plain_byte());
      end
   endtask

   // One well-formed frame of random kind and content.
   task automatic send_good_frame();
      logic dual;
      dual = 1'($urandom_range(0, 1));
      send_frame(dual, pick_range(SENSOR_IR), pick_range(SENSOR_US), FLAW_NONE);
   endtask

   // Directed frames: the first 'T' only brings the buffer in step. Then a
   // single frame with an all-zero reading, which is the too-close code, and a
   // dual frame with the largest and the most negative readings.
   task automatic test_frame_basics();
      req_idle_pct = 30;
      rsp_idle_pct = 30;
      send_byte(FRAME_MARK);
      send_frame(1'b0, 16'h0000, 16'h0000, FLAW_NONE);
      send_frame(1'b1, 16'h7FFF, 16'h8000, FLAW_NONE);
   endtask

   // Directed errors: a CRC mismatch on an all-ones reading, a 'T' arriving
   // with two bytes held, and an overflow where the eighth byte is dropped.
   // The final 'T' then lands on a buffer holding only its 'T'.
   task automatic test_frame_errors();
      send_frame(1'b0, 16'hFFFF, 16'h0000, FLAW_CRC);
      send_byte(FRAME_MARK);
      send_byte(8'h01);
      send_byte(FRAME_MARK);
      for (int i = 1; i <= FRAME_DEPTH; i++) begin
         send_byte(8'(i));
      end
      send_byte(FRAME_MARK);
   endtask

   // Both extremes of every register, each with a handful of frames.
   task automatic test_register_extremes();
      cfg_type c;
      c = '0;
      load_settings(c);
      repeat (8) send_good_frame();
      send_byte(FRAME_MARK);
      c = '1;
      load_settings(c);
      repeat (8) send_good_frame();
      send_byte(FRAME_MARK);
   endtask

   // Random traffic under a fresh register set. Most of it is well-formed
   // frames with random content; the rest is damaged frames and loose bytes,
   // some of them stray 'T's.
   task automatic test_random_traffic(input int n_items, input int sender_pct,
                                      input int receiver_pct);
      int stop_at;
      int pick;
      load_settings(random_settings());
      req_idle_pct = sender_pct;
      rsp_idle_pct = receiver_pct;
      stop_at = items_sent + n_items;
      while (items_sent < stop_at) begin
         pick = $urandom_range(0, 99);
         if (pick < 70) begin
            send_good_frame();
         end else if (pick < 85) begin
            case ($urandom_range(0, 2))
               0: send_frame(1'($urandom_range(0, 1)), pick_range(SENSOR_IR),
                             pick_range(SENSOR_US), FLAW_CRC);
               1: send_frame(1'($urandom_range(0, 1)), pick_range(SENSOR_IR),
                             pick_range(SENSOR_US), FLAW_SHORT);
               default: send_frame(1'($urandom_range(0, 1)), pick_range(SENSOR_IR),
                                   pick_range(SENSOR_US), FLAW_LONG);
            endcase
         end else begin
            repeat ($urandom_range(1, 4)) begin
               send_byte(($urandom_range(0, 7) == 0) ? FRAME_MARK : 8'($urandom));
            end
         end
      end
      send_byte(FRAME_MARK);
   endtask

   // The receiver holds off for a long stretch while the sender keeps offering
   // frames back to back, so the result buffer fills and the input stalls.
   task automatic test_backpressure();
      load_settings(random_settings());
      req_idle_pct = 0;
      rsp_idle_pct = 0;
      hold_go <= 1'b1;
      repeat (10) send_good_frame();
      send_byte(FRAME_MARK);
      hold_go <= 1'b0;
   endtask

   // A safety net: no correct run comes anywhere near this.
   initial begin
      #10_000_000;
      $display("simulation failed");
      $finish;
   end

   initial begin
      // Our copy of the block starts out in its reset state.
      regs.crc_poly       = 8'd7;
      regs.too_close_code = 16'd0;
      regs.ir_out_code    = 16'hFFFF;
      regs.us_out_code    = 16'hFFFF;
      regs.ir_min_mm      = 15'd200;
      regs.ir_max_mm      = 15'd14000;
      regs.us_min_mm      = 15'd50;
      regs.us_max_mm      = 15'd7650;
      held_bytes  = '0;
      held_count  = 0;
      frame_count = 32'd0;

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      test_frame_basics();
      test_frame_errors();
      test_register_extremes();
      // Sender lightly idle and receiver mostly stalled, then the reverse,
      // then neither side idles at all.
      test_random_traffic(400, 16, 77);
      test_random_traffic(400, 77, 16);
      test_random_traffic(400, 0, 0);
      test_backpressure();

      rsp_idle_pct = 0;
      wait_idle();
      if (error_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
